// ----- rtl/hsv_to_rgb_converter_defines.svh -----
// Assertion macros shared by the HSV to RGB converter.
`ifndef HSV_TO_RGB_CONVERTER_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define HTR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Plain invariant, checked on every rising clock edge outside reset.
`define HTR_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

// ----- rtl/htr_pkg.sv -----
// Package with the sector type and sector codes of the HSV to RGB converter.
package htr_pkg;

  // Width of the hexcone sector index.
  localparam int SECTOR_W = 3;

  typedef logic [SECTOR_W-1:0] sector_t;

  // Hexcone sectors, named after the hue span they cover.
  localparam sector_t SEC_RED_YELLOW    = 3'd0;
  localparam sector_t SEC_YELLOW_GREEN  = 3'd1;
  localparam sector_t SEC_GREEN_CYAN    = 3'd2;
  localparam sector_t SEC_CYAN_BLUE     = 3'd3;
  localparam sector_t SEC_BLUE_MAGENTA  = 3'd4;
  localparam sector_t SEC_MAGENTA_RED   = 3'd5;

  // Pipeline latency from an accepted word to its result strobe.
  localparam int LATENCY = 8;

endpackage

// ----- rtl/hsv_to_rgb_converter.sv -----
// Top level of the pipelined HSV to RGB converter.
// The converter takes one HSV word in every clock cycle: busy is never
// raised, so start alone accepts a word. Each result appears on out_red,
// out_green and out_blue for one cycle with out_valid high, in input
// order. The pipeline has eight register stages: input capture, sector
// split, the s*f multiply, the fraction terms, and the three-stage scale
// units that form p, q and t, followed by the sector select into the
// output register.
// The receiver cannot stall, so every result must be taken as it appears.
// Zero saturation needs no special path: p, q and t all equal value then.
module hsv_to_rgb_converter #(
  parameter int CHANNEL_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [CHANNEL_BITS-1:0] in_hue,
  input  logic [CHANNEL_BITS-1:0] in_saturation,
  input  logic [CHANNEL_BITS-1:0] in_brightness,
  output logic                    out_valid,
  output logic [CHANNEL_BITS-1:0] out_red,
  output logic [CHANNEL_BITS-1:0] out_green,
  output logic [CHANNEL_BITS-1:0] out_blue
);

  import htr_pkg::*;

  `include "hsv_to_rgb_converter_defines.svh"

  localparam int CB = CHANNEL_BITS;
  localparam logic [CB-1:0]   ONE  = {CB{1'b1}};
  localparam logic [2*CB-1:0] HALF = {{CB{1'b0}}, 1'b1, {(CB-1){1'b0}}};

  // Valid bits, one per register stage.
  logic [LATENCY-1:0] vld_r, vld_nxt;

  // Stage 1: captured input word.
  logic [CB-1:0] h1_r, s1_r, v1_r;
  // Stage 2: sector and fraction.
  logic [CB+2:0] h6;
  sector_t       sec2_r;
  logic [CB-1:0] f2_r, s2_r, v2_r;
  // Stage 3: product s*f.
  logic [2*CB-1:0] sf_prod3_r;
  sector_t         sec3_r;
  logic [CB-1:0]   s3_r, v3_r;
  // Stage 4: fractions of ONE for p, q and t.
  logic [2*CB-1:0] sf_sum, sfc_sum;
  logic [CB-1:0]   ap4_r, aq4_r, at4_r, ap_nxt, aq_nxt, at_nxt;
  sector_t         sec4_r;
  logic [CB-1:0]   v4_r;
  // Stages 5 to 7: sector and value ride along the scale units.
  sector_t       sec5_r, sec6_r, sec7_r;
  logic [CB-1:0] v5_r, v6_r, v7_r;
  logic [CB-1:0] p7, q7, t7;
  // Stage 8: output register.
  logic [CB-1:0] red_r, green_r, blue_r, red_nxt, green_nxt, blue_nxt;

  // The pipeline never stalls, so a word is accepted whenever start is high.
  assign busy = 1'b0;

  // Valid bits shift one stage per cycle.
  assign vld_nxt = {vld_r[LATENCY-2:0], start & ~busy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Hue times six: sector in the top bits, fraction in the low bits.
  assign h6 = ({3'b000, h1_r} << 2) + ({3'b000, h1_r} << 1);

  // Fraction terms: sf = round(s*f), sfc = round(s*(1-f)), both within ONE.
  always_comb begin
    sf_sum  = sf_prod3_r + HALF;
    sfc_sum = {s3_r, {CB{1'b0}}} - sf_prod3_r + HALF;
    ap_nxt  = ONE - s3_r;
    aq_nxt  = ONE - sf_sum[2*CB-1:CB];
    at_nxt  = ONE - sfc_sum[2*CB-1:CB];
  end

  // Front stages of the payload pipeline.
  always_ff @(posedge clk) begin
    h1_r <= in_hue;
    s1_r <= in_saturation;
    v1_r <= in_brightness;

    sec2_r <= h6[CB+2:CB];
    f2_r   <= h6[CB-1:0];
    s2_r   <= s1_r;
    v2_r   <= v1_r;

    sf_prod3_r <= {{CB{1'b0}}, s2_r} * {{CB{1'b0}}, f2_r};
    sec3_r     <= sec2_r;
    s3_r       <= s2_r;
    v3_r       <= v2_r;

    ap4_r  <= ap_nxt;
    aq4_r  <= aq_nxt;
    at4_r  <= at_nxt;
    sec4_r <= sec3_r;
    v4_r   <= v3_r;

    sec5_r <= sec4_r;
    sec6_r <= sec5_r;
    sec7_r <= sec6_r;
    v5_r   <= v4_r;
    v6_r   <= v5_r;
    v7_r   <= v6_r;
  end

  // Scale units for p = v(1-s), q = v(1-sf) and t = v(1-sfc).
  htr_scale #(.CHANNEL_BITS(CB)) u_scale_p (
    .clk (clk), .val (v4_r), .frac (ap4_r), .res (p7)
  );
  htr_scale #(.CHANNEL_BITS(CB)) u_scale_q (
    .clk (clk), .val (v4_r), .frac (aq4_r), .res (q7)
  );
  htr_scale #(.CHANNEL_BITS(CB)) u_scale_t (
    .clk (clk), .val (v4_r), .frac (at4_r), .res (t7)
  );

  // Pick value, p, q and t per hexcone sector.
  always_comb begin
    case (sec7_r)
      SEC_RED_YELLOW: begin
        red_nxt = v7_r; green_nxt = t7;   blue_nxt = p7;
      end
      SEC_YELLOW_GREEN: begin
        red_nxt = q7;   green_nxt = v7_r; blue_nxt = p7;
      end
      SEC_GREEN_CYAN: begin
        red_nxt = p7;   green_nxt = v7_r; blue_nxt = t7;
      end
      SEC_CYAN_BLUE: begin
        red_nxt = p7;   green_nxt = q7;   blue_nxt = v7_r;
      end
      SEC_BLUE_MAGENTA: begin
        red_nxt = t7;   green_nxt = p7;   blue_nxt = v7_r;
      end
      default: begin
        red_nxt = v7_r; green_nxt = p7;   blue_nxt = q7;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    red_r   <= red_nxt;
    green_r <= green_nxt;
    blue_r  <= blue_nxt;
  end

  assign out_valid = vld_r[LATENCY-1];
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

  // A result appears exactly when a word went in a full latency earlier.
  `HTR_ASSERT_ALWAYS(a_result_timing, out_valid == $past(start & ~busy, LATENCY), "result strobe out of step with accepted words")

  // One component always equals the brightness, and none exceeds it.
  `HTR_ASSERT_IMPL(a_max_is_value, out_valid, (out_red == $past(in_brightness, LATENCY) || out_green == $past(in_brightness, LATENCY) || out_blue == $past(in_brightness, LATENCY)) && out_red <= $past(in_brightness, LATENCY) && out_green <= $past(in_brightness, LATENCY) && out_blue <= $past(in_brightness, LATENCY), "largest component differs from brightness")

  // Zero saturation gives gray at the brightness level.
  `HTR_ASSERT_IMPL(a_gray, out_valid && $past(in_saturation == '0, LATENCY), out_red == $past(in_brightness, LATENCY) && out_green == out_red && out_blue == out_red, "zero saturation did not give gray")

endmodule

// ----- rtl/htr_scale.sv -----
// Three-stage unit that scales a value by a fraction of ONE with rounding.
module htr_scale #(
  parameter int CHANNEL_BITS = 16
) (
  input  logic                    clk,
  input  logic [CHANNEL_BITS-1:0] val,
  input  logic [CHANNEL_BITS-1:0] frac,
  output logic [CHANNEL_BITS-1:0] res
);

  localparam int CB = CHANNEL_BITS;
  localparam logic [CB-1:0]   ONE      = {CB{1'b1}};
  localparam logic [2*CB-1:0] HALF_ONE = {{(CB+1){1'b0}}, {(CB-1){1'b1}}};
  localparam logic [CB:0]     TWO_ONE  = {ONE, 1'b0};

  logic [2*CB-1:0] prod_r, prod_nxt;
  logic [2*CB-1:0] sum_r, sum_nxt;
  logic [CB-1:0]   res_r, res_nxt;
  logic [CB-1:0]   hi, lo;
  logic [CB:0]     fold;
  logic [CB-1:0]   corr;

  // First stage: the product of value and fraction.
  assign prod_nxt = {{CB{1'b0}}, val} * {{CB{1'b0}}, frac};

  // Second stage: add half of ONE so the division rounds to nearest.
  assign sum_nxt = prod_r + HALF_ONE;

  // Third stage: divide by 2^CB-1. With x = hi*2^CB + lo, the quotient is
  // hi plus (hi + lo) / ONE, and that second term is 0, 1 or 2.
  always_comb begin
    hi   = sum_r[2*CB-1:CB];
    lo   = sum_r[CB-1:0];
    fold = {1'b0, hi} + {1'b0, lo};
    if (fold >= TWO_ONE) begin
      corr = {{(CB-2){1'b0}}, 2'd2};
    end else if (fold >= {1'b0, ONE}) begin
      corr = {{(CB-1){1'b0}}, 1'b1};
    end else begin
      corr = '0;
    end
    res_nxt = hi + corr;
  end

  // Payload registers; validity travels alongside in the caller.
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    sum_r  <= sum_nxt;
    res_r  <= res_nxt;
  end

  assign res = res_r;

endmodule
